FILE: rtl/core/frst_pkg.sv
// shared types and constants of the fifo refill stall timing model
// no dependencies; imported by frst_div and fifo_refill_stall_timing_model
package frst_pkg;

    // fifo sizing
    localparam int MAX_DEPTH = 1024;
    localparam int LVL_W     = 11;
    localparam logic [LVL_W-1:0] MAX_DEPTH_L = LVL_W'(MAX_DEPTH);

    // field widths
    localparam int ADDR_W  = 32;
    localparam int CYC_W   = 48;
    localparam int COST_W  = 16;
    localparam int STALL_W = 16;
    localparam int PROD_W  = LVL_W + COST_W;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // serial divider sizing
    localparam int DIV_STEPS = CYC_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_START_ADDR = 3'd0;
    localparam logic [IDX_W-1:0] CFG_STOP_ADDR  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SEED_ADDR  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DATA_BASE  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DATA_LIMIT = 3'd4;
    localparam logic [IDX_W-1:0] CFG_CAPACITY   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_GEN_COST   = 3'd6;

    // result kinds
    typedef enum logic [2:0] {
        KIND_REG   = 3'd0,
        KIND_DATA  = 3'd1,
        KIND_START = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_SEED  = 3'd4,
        KIND_ERR   = 3'd5
    } kind_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/core/frst_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on frst_pkg for widths and the status struct
module frst_div
    import frst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [CYC_W-1:0]  dividend,
    input  logic [COST_W-1:0] divisor,
    output logic [CYC_W-1:0]  quotient,
    output div_stat_t         stat
);

    logic [CYC_W-1:0]  dvd_reg;
    logic [COST_W-1:0] dsr_reg;
    logic [COST_W-1:0] rem_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [COST_W:0]   trial;
    logic              trial_ge;

    // one trial subtraction per step
    assign trial    = {rem_reg, dvd_reg[CYC_W-1]};
    assign trial_ge = trial >= {1'b0, dsr_reg};

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= trial_ge ? COST_W'(trial - {1'b0, dsr_reg}) : trial[COST_W-1:0];
            dvd_reg <= {dvd_reg[CYC_W-2:0], trial_ge};
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/core/fifo_refill_stall_timing_model.sv
// top level: access decode, catch-up sequencer and fifo timing state
// depends on frst_pkg and frst_div
//
// Each item is one bus access (op, addr, now_cycle), taken when start is high
// and busy is low; its result appears on the result ports for one cycle with
// done high and must be taken then. Register accesses, control writes and decode
// faults are answered from the decode state; data reads that need no catch-up skip the divider. A data
// read that has to catch up on generation divides the elapsed cycles by the
// generation cost in a 48-step serial divider, then scales and adds before
// taking its element. busy falls in the done cycle, so the next access can be
// taken as soon as the result of the last one appears.
module fifo_refill_stall_timing_model
    import frst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [CYC_W-1:0]   now_cycle,
    output logic               done,
    output logic [2:0]         kind,
    output logic [STALL_W-1:0] stall_res,
    output logic               gen_event,
    output logic [CYC_W-1:0]   gen_ready_cycle,
    output logic [LVL_W-1:0]   fill_level,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DEC  = 8'b0000_0010,
        ST_DIV  = 8'b0000_0100,
        ST_MUL  = 8'b0000_1000,
        ST_ADD  = 8'b0001_0000,
        ST_P0   = 8'b0010_0000,
        ST_P1   = 8'b0100_0000,
        ST_P2   = 8'b1000_0000
    } st_t;

    // configuration
    logic [ADDR_W-1:0] start_addr_reg, stop_addr_reg, seed_addr_reg;
    logic [ADDR_W-1:0] base_reg, limit_reg;
    logic [LVL_W-1:0]  cap_reg;
    logic [COST_W-1:0] cost_reg;

    // sequencer and timing state
    st_t               state_reg, state_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [CYC_W-1:0]  lgc_reg, lgc_next;
    logic              running_reg, running_next;
    logic              held_reg, held_next;

    // per-item work registers
    logic              op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CYC_W-1:0]  now_reg;
    logic [LVL_W-1:0]  n_reg, n_next;
    logic [PROD_W-1:0] prod_reg;
    logic [CYC_W:0]    nxt_reg;
    logic [CYC_W-1:0]  t3_reg, t3_next;
    logic              cu3_reg, cu3_next;
    logic [STALL_W-1:0] stl_reg, stl_next;
    logic              ev_reg, ev_next;
    logic [CYC_W-1:0]  rdy_reg, rdy_next;

    // result registers
    logic              done_reg;
    kind_t             kind_reg;
    logic [STALL_W-1:0] stall_out_reg;
    logic              ev_out_reg;
    logic [CYC_W-1:0]  rdy_out_reg;
    logic [LVL_W-1:0]  fill_out_reg;

    // result being produced this cycle
    logic              emit;
    kind_t             emit_kind;
    logic [STALL_W-1:0] emit_stall;
    logic              emit_ev;
    logic [CYC_W-1:0]  emit_rdy;
    logic [LVL_W-1:0]  emit_fill;

    // decode and arithmetic helpers
    logic [LVL_W-1:0]  ecap;
    logic              below_cap;
    logic [LVL_W-1:0]  room;
    logic [LVL_W-1:0]  fill_up;
    logic              eq_start, eq_stop, eq_seed, in_window, claimed;
    logic [CYC_W-1:0]  diff_now;
    logic              nxt_gt;
    logic [CYC_W:0]    stall_full;
    logic [STALL_W-1:0] stall_sat;

    // divider
    logic              div_go;
    logic [CYC_W-1:0]  div_q;
    div_stat_t         div_stat;
    logic              q_ge_room;

    frst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (diff_now),
        .divisor  (cost_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // capacity in use and room left
    assign ecap      = (cap_reg > MAX_DEPTH_L) ? MAX_DEPTH_L : cap_reg;
    assign below_cap = level_reg < ecap;
    assign room      = below_cap ? LVL_W'(ecap - level_reg) : '0;
    assign fill_up   = below_cap ? ecap : level_reg;

    // address decode
    assign eq_start  = addr_reg == start_addr_reg;
    assign eq_stop   = addr_reg == stop_addr_reg;
    assign eq_seed   = addr_reg == seed_addr_reg;
    assign in_window = (addr_reg >= base_reg) && (addr_reg < limit_reg);
    assign claimed   = (ecap != '0) && (eq_start || eq_stop || eq_seed || in_window);

    // elapsed cycles since last generation, zero if time ran backward
    assign diff_now  = (now_reg >= lgc_reg) ? CYC_W'(now_reg - lgc_reg) : '0;
    assign q_ge_room = div_q >= {{(CYC_W-LVL_W){1'b0}}, room};

    // stall until the next element of an empty fifo
    assign nxt_gt     = nxt_reg > {1'b0, now_reg};
    assign stall_full = nxt_gt ? (nxt_reg - {1'b0, now_reg}) : '0;
    assign stall_sat  = (|stall_full[CYC_W:STALL_W]) ? '1 : stall_full[STALL_W-1:0];

    assign busy = state_reg != ST_IDLE;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        level_next   = level_reg;
        lgc_next     = lgc_reg;
        running_next = running_reg;
        held_next    = held_reg;
        n_next       = n_reg;
        t3_next      = t3_reg;
        cu3_next     = cu3_reg;
        stl_next     = stl_reg;
        ev_next      = ev_reg;
        rdy_next     = rdy_reg;
        div_go       = 1'b0;
        emit         = 1'b0;
        emit_kind    = KIND_ERR;
        emit_stall   = '0;
        emit_ev      = 1'b0;
        emit_rdy     = '0;
        emit_fill    = level_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                state_next = ST_IDLE;
                emit       = 1'b1;
                priority if (!claimed)
                begin
                    emit_kind = KIND_ERR;
                end
                else if (op_reg)
                begin
                    priority if (eq_start)
                    begin
                        if (!running_reg)
                        begin
                            running_next = 1'b1;
                            held_next    = 1'b0;
                            lgc_next     = now_reg;
                        end
                        emit_kind = KIND_START;
                    end
                    else if (eq_stop)
                    begin
                        running_next = 1'b0;
                        held_next    = 1'b0;
                        level_next   = '0;
                        emit_kind    = KIND_STOP;
                        emit_fill    = '0;
                    end
                    else if (eq_seed)
                    begin
                        emit_kind = KIND_SEED;
                    end
                    else
                    begin
                        emit_kind = KIND_ERR;
                    end
                end
                else if (!in_window)
                begin
                    emit_kind = KIND_REG;
                end
                else if (!running_reg)
                begin
                    emit_kind = KIND_ERR;
                end
                else
                begin
                    // data read: catch up on generation first
                    emit = 1'b0;
                    priority if (held_reg)
                    begin
                        state_next = ST_P0;
                    end
                    else if (cost_reg == '0)
                    begin
                        level_next = fill_up;
                        held_next  = 1'b1;
                        state_next = ST_P0;
                    end
                    else if (room == '0)
                    begin
                        held_next  = 1'b1;
                        state_next = ST_P0;
                    end
                    else
                    begin
                        div_go     = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (q_ge_room)
                    begin
                        n_next    = room;
                        held_next = 1'b1;
                    end
                    else
                    begin
                        n_next = div_q[LVL_W-1:0];
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                level_next = level_reg + n_reg;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                lgc_next   = lgc_reg + {{(CYC_W-PROD_W){1'b0}}, prod_reg};
                state_next = ST_P0;
            end
            ST_P0:
            begin
                state_next = ST_P1;
            end
            ST_P1:
            begin
                if ((level_reg == '0) && held_reg)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ERR;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // take one element, waiting for it if the fifo is empty
                    held_next  = 1'b0;
                    state_next = ST_P2;
                    if (level_reg == '0)
                    begin
                        stl_next = stall_sat;
                        ev_next  = 1'b1;
                        rdy_next = nxt_reg[CYC_W-1:0];
                        t3_next  = nxt_gt ? nxt_reg[CYC_W-1:0] : now_reg;
                        cu3_next = ecap == LVL_W'(1);
                        lgc_next = (ecap == LVL_W'(1)) ? t3_next : nxt_reg[CYC_W-1:0];
                    end
                    else
                    begin
                        level_next = level_reg - 1'b1;
                        stl_next   = '0;
                        ev_next    = 1'b0;
                        rdy_next   = '0;
                        t3_next    = now_reg;
                        cu3_next   = held_reg;
                        lgc_next   = held_reg ? now_reg : lgc_reg;
                    end
                end
            end
            ST_P2:
            begin
                // a freed slot restarts generation from the read's end
                if (cu3_reg)
                begin
                    priority if (ev_reg && nxt_reg[CYC_W])
                    begin
                        // read ended past the cycle wrap: the freed slot refills at once
                        level_next = fill_up;
                        held_next  = 1'b1;
                        lgc_next   = lgc_reg + {{(CYC_W-COST_W){1'b0}}, cost_reg};
                    end
                    else if (cost_reg == '0)
                    begin
                        level_next = fill_up;
                        held_next  = 1'b1;
                    end
                    else if (room == '0)
                    begin
                        held_next = 1'b1;
                    end
                    else
                    begin
                        held_next = 1'b0;
                    end
                end
                emit       = 1'b1;
                emit_kind  = KIND_DATA;
                emit_stall = stl_reg;
                emit_ev    = ev_reg;
                emit_rdy   = rdy_reg;
                emit_fill  = level_next;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            level_reg   <= '0;
            lgc_reg     <= '0;
            running_reg <= 1'b0;
            held_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            lgc_reg     <= lgc_next;
            running_reg <= running_next;
            held_reg    <= held_next;
            done_reg    <= emit;
        end
    end

    // item capture and work registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            op_reg   <= op;
            addr_reg <= addr;
            now_reg  <= now_cycle;
        end
        n_reg    <= n_next;
        prod_reg <= PROD_W'(n_reg) * PROD_W'(cost_reg);
        nxt_reg  <= {1'b0, lgc_reg} + {{(CYC_W+1-COST_W){1'b0}}, cost_reg};
        t3_reg   <= t3_next;
        cu3_reg  <= cu3_next;
        stl_reg  <= stl_next;
        ev_reg   <= ev_next;
        rdy_reg  <= rdy_next;
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg      <= emit_kind;
            stall_out_reg <= emit_stall;
            ev_out_reg    <= emit_ev;
            rdy_out_reg   <= emit_rdy;
            fill_out_reg  <= emit_fill;
        end
    end

    assign done            = done_reg;
    assign kind            = kind_reg;
    assign stall_res       = stall_out_reg;
    assign gen_event       = ev_out_reg;
    assign gen_ready_cycle = rdy_out_reg;
    assign fill_level      = fill_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg <= '0;
            stop_addr_reg  <= '0;
            seed_addr_reg  <= '0;
            base_reg       <= '0;
            limit_reg      <= '0;
            cap_reg        <= '0;
            cost_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_ADDR: start_addr_reg <= cfg_data;
                CFG_STOP_ADDR:  stop_addr_reg  <= cfg_data;
                CFG_SEED_ADDR:  seed_addr_reg  <= cfg_data;
                CFG_DATA_BASE:  base_reg       <= cfg_data;
                CFG_DATA_LIMIT: limit_reg      <= cfg_data;
                CFG_CAPACITY:   cap_reg        <= cfg_data[LVL_W-1:0];
                CFG_GEN_COST:   cost_reg       <= cfg_data[COST_W-1:0];
                default:        ;
            endcase
        end
    end

    // a result strobe always ends a busy stretch
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // the divider only runs while the sequencer waits on it
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider active outside the divide state");

    // the fill level never passes the deepest fifo
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= MAX_DEPTH_L)
        else $error("fifo level above maximum depth");

    // only a data read can report a wait for generation
    a_event_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && gen_event) |-> (kind_reg == KIND_DATA))
        else $error("generation event on a non data item");

    // a stall is only reported together with its generation event
    a_stall_has_event: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (stall_res != '0)) |-> gen_event)
        else $error("stall reported without generation event");

endmodule
